// ===== hw/rtl/wdnd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdnd_pkg
// shared types and constants for the windowed near-duplicate detector
// ----------------------------------------------------------------------------
package wdnd_pkg;

  localparam int WINDOW_MAX_DEF = 64;
  localparam int SPAN_W         = 7;
  localparam int TOL_W          = 31;
  localparam int SAMPLE_W       = 32;
  localparam int WIDE_W         = SAMPLE_W + 1;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_WINDOW_SPAN = 1'b0,
    REG_TOLERANCE   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first;
  } in_word_t;

  typedef struct packed {
    logic near_hit;
    logic found_so_far;
  } out_word_t;

  // control broadcast to every cell of the chain, with clear held low at the head
  typedef struct packed {
    logic                     shift;
    logic                     clear;
    logic signed [WIDE_W-1:0] lo;
    logic signed [WIDE_W-1:0] hi;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/window_near_duplicate_detect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_near_duplicate_detect
// flags samples lying within a tolerance of any of the last window_span
// samples of the same sequence, plus a sticky per-sequence hit flag
// ----------------------------------------------------------------------------
//  channel  direction  handshake                   word
//  in_      input      in_valid / in_ready         in_data  (sample, first)
//  out_     output     out_valid / out_ready       out_data (near_hit, found_so_far)
//  apb      input      psel/penable/pwrite/pready  paddr, pwdata, prdata
//
//  one word per cycle sustained while out_ready holds high; an accepted word
//  reaches its result through the band register and then the output register
//  the chain of WINDOW_MAX cells compares every entry in parallel, combinationally
//  synchronous reset clears the valid bits, the sticky flag and the config registers
//  a stalled output holds the band stage; in_ready drops only when both are full
// ----------------------------------------------------------------------------
module window_near_duplicate_detect #(
  parameter int WINDOW_MAX = wdnd_pkg::WINDOW_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  wdnd_pkg::in_word_t             in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output wdnd_pkg::out_word_t            out_data,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wdnd_pkg::ADDR_W-1:0]    paddr,
  input  logic [wdnd_pkg::DATA_W-1:0]    pwdata,
  output logic [wdnd_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import wdnd_pkg::*;

  // configuration registers
  logic [SPAN_W-1:0] span_r;
  logic [TOL_W-1:0]  tol_r;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  // band stage: the accepted word and its tolerance band
  logic                     a_v_r;
  in_word_t                 a_word_r;
  logic signed [WIDE_W-1:0] a_lo_r;
  logic signed [WIDE_W-1:0] a_hi_r;
  logic signed [WIDE_W-1:0] s_wide;
  logic signed [WIDE_W-1:0] t_wide;

  // output stage
  logic      o_v_r;
  out_word_t o_word_r;
  logic      found_r;
  logic      found_nxt;

  logic      in_acc;
  logic      advance;
  logic      hit_any;

  cell_cmd_t cmd;
  cell_cmd_t cmd_head;

  // chain taps: index 0 is the new sample entering the chain
  logic [SAMPLE_W-1:0] chain_val [WINDOW_MAX+1];
  logic                chain_vld [WINDOW_MAX+1];
  logic [WINDOW_MAX-1:0] cell_hit;
  logic [WINDOW_MAX-1:0] win_en;

  // ---------------------------------------------------------------- apb
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= '0;
      tol_r  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WINDOW_SPAN: span_r <= pwdata[SPAN_W-1:0];
        REG_TOLERANCE:   tol_r  <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW_SPAN: prdata = {{(DATA_W-SPAN_W){1'b0}}, span_r};
      REG_TOLERANCE:   prdata = {{(DATA_W-TOL_W){1'b0}}, tol_r};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow
  // the band stage moves on when the output register is free or being drained
  assign advance  = a_v_r & (~o_v_r | out_ready);
  assign in_ready = ~a_v_r | advance;
  assign in_acc   = in_valid & in_ready;

  // band [s - tol, s + tol] at 33 bits, so no wrap
  assign s_wide = {in_data.sample[SAMPLE_W-1], in_data.sample};
  assign t_wide = {{(WIDE_W-TOL_W){1'b0}}, tol_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (in_acc) begin
      a_v_r <= 1'b1;
    end else if (advance) begin
      a_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_word_r <= in_data;
      a_lo_r   <= s_wide - t_wide;
      a_hi_r   <= s_wide + t_wide;
    end
  end

  // ---------------------------------------------------------------- chain
  // a first word clears every older entry as it shifts; the head cell
  // always takes the new sample as valid
  always_comb begin
    cmd.shift      = advance;
    cmd.clear      = a_word_r.first;
    cmd.lo         = a_lo_r;
    cmd.hi         = a_hi_r;
    cmd_head       = cmd;
    cmd_head.clear = 1'b0;
  end

  assign chain_val[0] = a_word_r.sample;
  assign chain_vld[0] = 1'b1;

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    // cell g is looked at when its distance g+1 lies within the span
    assign win_en[g] = (32'(span_r) > 32'(g));

    wdnd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      ((g == 0) ? cmd_head : cmd),
      .win_en   (win_en[g]),
      .prev_val (chain_val[g]),
      .prev_vld (chain_vld[g]),
      .val      (chain_val[g+1]),
      .vld      (chain_vld[g+1]),
      .hit      (cell_hit[g])
    );
  end

  // a first word starts a new sequence, so its hits are masked and it never hits
  assign hit_any   = (|cell_hit) & ~a_word_r.first;
  assign found_nxt = a_word_r.first ? 1'b0 : (found_r | hit_any);

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (advance) begin
        o_v_r   <= 1'b1;
        found_r <= found_nxt;
      end else if (out_ready) begin
        o_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_word_r.near_hit     <= hit_any;
      o_word_r.found_so_far <= found_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_word_r;

  // ---------------------------------------------------------------- checks
  // a full band stage that cannot move must hold off the input
  a_hold_off: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && !advance) |-> !in_ready)
    else $error("input taken while band stage blocked");

  // a hit is always reflected in the sticky flag
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.near_hit || out_data.found_so_far))
    else $error("near hit without sticky flag");

  // a first word restarts the sequence with no hit
  a_first_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && a_word_r.first) |=> (!out_data.near_hit && !out_data.found_so_far))
    else $error("first word reported a hit");

  // a zero window never matches
  a_zero_span: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && span_r == '0) |=> !out_data.near_hit)
    else $error("hit with zero window");

  // the head cell is valid once a word has shifted in
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> chain_vld[1])
    else $error("head cell not valid after shift");

endmodule

// ===== hw/rtl/wdnd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdnd_cell
// one history entry: holds a sample and its valid bit, compares against
// the current tolerance band and passes its entry on to the next cell
// ----------------------------------------------------------------------------
module wdnd_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wdnd_pkg::cell_cmd_t                 cmd,
  input  logic                                win_en,
  input  logic [wdnd_pkg::SAMPLE_W-1:0]       prev_val,
  input  logic                                prev_vld,
  output logic [wdnd_pkg::SAMPLE_W-1:0]       val,
  output logic                                vld,
  output logic                                hit
);
  import wdnd_pkg::*;

  logic [SAMPLE_W-1:0]      val_r;
  logic                     vld_r;
  logic signed [WIDE_W-1:0] val_wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (cmd.shift) begin
      vld_r <= prev_vld & ~cmd.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      val_r <= prev_val;
    end
  end

  assign val_wide = {val_r[SAMPLE_W-1], val_r};
  assign hit      = vld_r & win_en & (val_wide >= cmd.lo) & (val_wide <= cmd.hi);
  assign val      = val_r;
  assign vld      = vld_r;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for window_near_duplicate_detect: a queue-fed driver
// streams sample words with random gaps, a clocked monitor predicts each
// accepted word's hit flags and checks every result word in order, and the
// window and tolerance registers are rewritten over the apb port between
// phases while the block is idle
// ----------------------------------------------------------------------------
module tb;
  import wdnd_pkg::*;

  localparam int WIN        = WINDOW_MAX_DEF;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN_WAIT = 10;
  localparam int SHOW_MAX   = 10;

  // clock, reset and block ports; the bench-driven inputs are known from time zero
  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_word_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_word_t           out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // predictor state: entry 0 holds the most recent sample
  logic signed [SAMPLE_W-1:0] hist_vals [WIN];
  logic [WIN-1:0]             hist_live = '0;
  logic                       seq_found = 1'b0;
  logic [SPAN_W-1:0]          span_reg  = '0;
  logic [TOL_W-1:0]           tol_reg   = '0;

  // words waiting for the driver, and hit flags owed by the block
  in_word_t  words_todo [$];
  out_word_t hits_due [$];
  // recent generated samples, newest first, used to aim near values
  logic signed [SAMPLE_W-1:0] gen_recent [$];

  int   words_queued   = 0;
  int   words_taken    = 0;
  int   mismatch_cnt   = 0;
  int   cycle_cnt      = 0;
  int   idle_pct       = 10;
  logic in_took        = 1'b0;

  window_near_duplicate_detect i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // hit flags for one accepted word; also advances the history chain
  function automatic out_word_t predict_near_hit(input in_word_t w);
    int        span;
    longint    diff;
    logic      hit;
    out_word_t res;
    hit = 1'b0;
    // a first word clears the chain and the sticky flag before comparing
    if (w.first) begin
      hist_live = '0;
      seq_found = 1'b0;
    end
    // a window wider than the chain saturates
    span = (int'(span_reg) > WIN) ? WIN : int'(span_reg);
    for (int i = 0; i < span; i++) begin
      if (hist_live[i]) begin
        // exact 33-bit difference, no wrap
        diff = longint'(w.sample) - longint'(hist_vals[i]);
        if (diff < 0) diff = -diff;
        if (diff <= longint'(tol_reg)) hit = 1'b1;
      end
    end
    for (int i = WIN - 1; i > 0; i--) hist_vals[i] = hist_vals[i-1];
    hist_vals[0] = w.sample;
    hist_live    = {hist_live[WIN-2:0], 1'b1};
    if (hit) seq_found = 1'b1;
    res.near_hit     = hit;
    res.found_so_far = seq_found;
    return res;
  endfunction

  // driver: new words and out_ready change on the falling edge
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (words_todo.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_data  <= words_todo.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // monitor: handshakes sampled on the rising edge
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end else if (rst_n) begin
      in_took <= in_valid && in_ready;
      // check before predicting: a result can never belong to this edge's word
      if (out_valid && out_ready) begin
        if (hits_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= SHOW_MAX)
            $display("unexpected result word: near_hit=%0b found=%0b",
                     out_data.near_hit, out_data.found_so_far);
        end else begin
          out_word_t want;
          want = hits_due.pop_front();
          if (out_data.near_hit !== want.near_hit ||
              out_data.found_so_far !== want.found_so_far) begin
            mismatch_cnt++;
            if (mismatch_cnt <= SHOW_MAX)
              $display("result mismatch: near_hit exp %0b got %0b, found exp %0b got %0b",
                       want.near_hit, out_data.near_hit,
                       want.found_so_far, out_data.found_so_far);
          end
        end
      end
      if (in_valid && in_ready) begin
        hits_due.push_back(predict_near_hit(in_data));
        words_taken <= words_taken + 1;
      end
    end
  end

  // apb write: setup then access, register taken at the access edge
  task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WINDOW_SPAN) span_reg = val[SPAN_W-1:0];
    else tol_reg = val[TOL_W-1:0];
  endtask

  task automatic set_window(input int span, input logic [DATA_W-1:0] tol);
    apb_write(REG_WINDOW_SPAN, DATA_W'(span));
    apb_write(REG_TOLERANCE, tol);
  endtask

  task automatic push_word(input logic signed [SAMPLE_W-1:0] s, input logic first);
    in_word_t w;
    w.sample = s;
    w.first  = first;
    words_todo.push_back(w);
    words_queued++;
    gen_recent.push_front(s);
    if (gen_recent.size() > WIN + 2) void'(gen_recent.pop_back());
  endtask

  // wait until every queued word is in and every result is out
  task automatic drain();
    while (words_taken != words_queued || hits_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // random word: half the time aimed near a sample inside or just past the window
  task automatic push_random_word();
    int          pick;
    int          k;
    int          reach;
    longint      mag;
    longint      val;
    logic        first;
    pick  = $urandom_range(0, 99);
    first = ($urandom_range(0, 99) < 3);
    if (pick < 25 || gen_recent.size() == 0) begin
      val = longint'($signed($urandom));
    end else if (pick < 75) begin
      reach = (int'(span_reg) + 1 < gen_recent.size()) ? int'(span_reg) + 1
                                                       : gen_recent.size();
      k = $urandom_range(0, reach - 1);
      case ($urandom_range(0, 3))
        0: mag = longint'(tol_reg);
        1: mag = longint'(tol_reg) + 1;
        default: mag = longint'($urandom_range(0, tol_reg));
      endcase
      if ($urandom_range(0, 1)) mag = -mag;
      val = longint'(gen_recent[k]) + mag;
    end else if (pick < 92) begin
      val = longint'($urandom_range(0, 15)) - 8;
    end else begin
      case ($urandom_range(0, 3))
        0: val = -64'sd2147483648;
        1: val = 64'sd2147483647;
        2: val = -64'sd2147483647;
        default: val = 64'sd2147483646;
      endcase
    end
    push_word(val[SAMPLE_W-1:0], first);
  endtask

  task automatic random_phase(input int span, input logic [DATA_W-1:0] tol,
                              input int count, input int idle);
    set_window(span, tol);
    idle_pct = idle;
    for (int n = 0; n < count; n++) push_random_word();
    drain();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset window of zero: nothing can hit, and no first mark is given
    push_word(32'sd5, 1'b0);
    push_word(32'sd5, 1'b0);
    push_word(32'sd5, 1'b0);
    drain();

    // widest window and tolerance: value extremes, exact 33-bit distance
    set_window(WIN, 32'h7FFF_FFFF);
    push_word(32'sd0, 1'b1);
    push_word(32'sd2147483647, 1'b0);   // distance equals the tolerance
    push_word(-32'sd2147483648, 1'b0);  // beyond the tolerance from both
    push_word(-32'sd2147483648, 1'b0);
    push_word(-32'sd2147483648, 1'b1);  // first word never hits
    push_word(32'sd2147483647, 1'b0);
    drain();

    // span register beyond the chain saturates, zero tolerance needs equality
    set_window(127, 32'h0);
    push_word(32'sd5, 1'b1);
    push_word(32'sd6, 1'b0);
    push_word(32'sd5, 1'b0);
    push_word(-32'sd1, 1'b0);
    drain();

    // window of one: only the newest entry counts
    set_window(1, 32'd3);
    push_word(32'sd10, 1'b1);
    push_word(32'sd13, 1'b0);
    push_word(32'sd20, 1'b0);
    push_word(32'sd10, 1'b0);
    push_word(32'sd17, 1'b0);
    push_word(32'sd21, 1'b1);
    drain();

    // random phases across spans and tolerances, one without any gaps
    random_phase(64, $urandom_range(0, 1000), 160, 10);
    random_phase(1, 0, 140, 10);
    random_phase(2, $urandom_range(0, 20), 140, 10);
    random_phase(127, 100, 140, 10);
    random_phase(0, 50, 100, 10);
    random_phase(17, $urandom & 32'h7FFF_FFFF, 140, 10);
    random_phase(64, 32'h7FFF_FFFF, 100, 10);
    random_phase(64, 10, 260, 0);

    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatch_cnt == 0 && hits_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
